// ===== hdl/dost_pkg.sv =====
// ----------------------------------------------------------------------------
// dost_pkg
// Shared types and codes for the deferred one-shot timer array.
// ----------------------------------------------------------------------------
package dost_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_TIMER_SLOTS = 16;
    localparam int DEF_TIME_WIDTH  = 32;

    // Request function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // Timer kinds
    localparam logic KIND_PLAIN  = 1'b0;
    localparam logic KIND_TICKED = 1'b1;

    // One request
    typedef struct packed {
        logic [1:0]  func;
        logic        timer_kind;
        logic [3:0]  timer_id;
        logic [31:0] duration;
        logic [31:0] delta;
    } t_req;

    // One event
    typedef struct packed {
        logic        event_kind;
        logic [3:0]  event_id;
        logic [31:0] event_delta;
        logic        last;
    } t_evt;

    // Status from the shared slot unit
    typedef struct packed {
        logic expired;
        logic emit;
    } t_unit_res;

endpackage

// ===== hdl/deferred_one_shot_timer_array.sv =====
// ----------------------------------------------------------------------------
// deferred_one_shot_timer_array
// Two tables of one-shot timer slots (plain and ticked) with deferred start
// and stop, advanced by tick requests.
// ----------------------------------------------------------------------------
// Start and stop requests keep busy low. A tick request raises busy: an apply
// state applies the pending stops and starts, then one shared add/compare
// unit walks every slot of both tables, one slot per cycle, through the
// elapsed-time and duration memories, followed by a drain state and a flush
// state. Events leave on o_evt for exactly one cycle each, marked by o_strobe,
// plain slots first then ticked slots, each in ascending number; the receiver
// cannot stall them, and the one marked last is the final event of that tick.
// A tick with no event raises no strobe. The last event is presented in the
// cycle after the flush, the same cycle in which busy drops, so the next
// request can be taken at the edge that ends it.
// ----------------------------------------------------------------------------
module deferred_one_shot_timer_array #(
    parameter int TIMER_SLOTS = dost_pkg::DEF_TIMER_SLOTS,
    parameter int TIME_WIDTH  = dost_pkg::DEF_TIME_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dost_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_strobe,
    output dost_pkg::t_evt  o_evt
);

    localparam int ALL_SLOTS = 2 * TIMER_SLOTS;
    localparam int SLOT_IW   = $clog2(ALL_SLOTS);
    localparam int NUM_W     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_APPLY = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    // Slot index from kind and number
    function automatic logic [SLOT_IW-1:0] f_slot(input logic kind,
                                                  input logic [NUM_W-1:0] num);
        logic [SLOT_IW-1:0] base;
        base = kind ? SLOT_IW'(TIMER_SLOTS) : '0;
        return base + SLOT_IW'(num);
    endfunction

    // Control state
    logic [2:0]           r_state,  n_state;
    logic [ALL_SLOTS-1:0] r_active, n_active;
    logic [ALL_SLOTS-1:0] r_startp, n_startp;
    logic [ALL_SLOTS-1:0] r_stop,   n_stop;
    logic [ALL_SLOTS-1:0] r_fresh,  n_fresh;
    logic                 r_kind,   n_kind;
    logic [NUM_W-1:0]     r_num,    n_num;
    logic                 r_b_vld,  n_b_vld;
    logic                 r_hold_vld, n_hold_vld;
    logic                 r_strobe, n_strobe;

    // Payload state
    logic [TIME_WIDTH-1:0] r_delta, n_delta;
    logic                  r_b_kind;
    logic [NUM_W-1:0]      r_b_num;
    dost_pkg::t_evt        r_hold, n_hold;
    dost_pkg::t_evt        r_out,  n_out;

    // Datapath wires
    logic                  req_go;
    logic                  id_ok;
    logic [NUM_W-1:0]      req_num;
    logic [SLOT_IW-1:0]    req_idx;
    logic [SLOT_IW-1:0]    req_idx0;
    logic [SLOT_IW-1:0]    req_idx1;
    logic                  dur_we;
    logic [TIME_WIDTH-1:0] dur_rdata;
    logic [TIME_WIDTH-1:0] ela_rdata;
    logic [SLOT_IW-1:0]    walk_idx;
    logic [SLOT_IW-1:0]    b_idx;
    logic [SLOT_IW-1:0]    b_idx0;
    logic [SLOT_IW-1:0]    b_idx1;
    logic                  b_live;
    logic [TIME_WIDTH-1:0] b_base;
    logic [TIME_WIDTH-1:0] b_sum;
    dost_pkg::t_unit_res   b_res;
    dost_pkg::t_evt        b_evt;

    // Decode the request
    assign req_go   = start && (r_state == ST_IDLE);
    assign id_ok    = (32'(i_req.timer_id) < 32'(TIMER_SLOTS));
    assign req_num  = NUM_W'(i_req.timer_id);
    assign req_idx  = f_slot(i_req.timer_kind, req_num);
    assign req_idx0 = f_slot(dost_pkg::KIND_PLAIN, req_num);
    assign req_idx1 = f_slot(dost_pkg::KIND_TICKED, req_num);
    assign dur_we   = req_go && (i_req.func == dost_pkg::FUNC_START) && id_ok
                      && !r_active[req_idx] && !r_startp[req_idx];

    // Walk and stage-B slot indexes
    assign walk_idx = f_slot(r_kind, r_num);
    assign b_idx    = f_slot(r_b_kind, r_b_num);
    assign b_idx0   = f_slot(dost_pkg::KIND_PLAIN, r_b_num);
    assign b_idx1   = f_slot(dost_pkg::KIND_TICKED, r_b_num);
    assign b_live   = r_b_vld && r_active[b_idx];
    assign b_base   = r_fresh[b_idx] ? '0 : ela_rdata;

    // Durations: written by start, read during the walk
    dost_slot_ram #(
        .DEPTH (ALL_SLOTS),
        .WIDTH (TIME_WIDTH),
        .AW    (SLOT_IW)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (dur_we),
        .i_waddr (req_idx),
        .i_wdata (TIME_WIDTH'(i_req.duration)),
        .i_raddr (walk_idx),
        .o_rdata (dur_rdata)
    );

    // Elapsed times: read ahead, written back one slot behind
    dost_slot_ram #(
        .DEPTH (ALL_SLOTS),
        .WIDTH (TIME_WIDTH),
        .AW    (SLOT_IW)
    ) u_ela_ram (
        .i_clk   (i_clk),
        .i_we    (b_live),
        .i_waddr (b_idx),
        .i_wdata (b_sum),
        .i_raddr (walk_idx),
        .o_rdata (ela_rdata)
    );

    // Shared add/compare unit
    dost_unit #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_unit (
        .i_base     (b_base),
        .i_delta    (r_delta),
        .i_duration (dur_rdata),
        .i_kind     (r_b_kind),
        .o_sum      (b_sum),
        .o_res      (b_res)
    );

    // Event for the slot in stage B
    always_comb begin
        b_evt.event_kind  = r_b_kind;
        b_evt.event_id    = 4'(r_b_num);
        b_evt.event_delta = (r_b_kind == dost_pkg::KIND_TICKED) ? 32'(r_delta) : 32'd0;
        b_evt.last        = 1'b0;
    end

    // Sequencer, slot flags and event holding
    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_startp   = r_startp;
        n_stop     = r_stop;
        n_fresh    = r_fresh;
        n_kind     = r_kind;
        n_num      = r_num;
        n_delta    = r_delta;
        n_b_vld    = 1'b0;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        n_strobe   = 1'b0;
        n_out      = r_out;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req.func)
                        dost_pkg::FUNC_TICK: begin
                            n_delta = TIME_WIDTH'(i_req.delta);
                            n_state = ST_APPLY;
                        end
                        dost_pkg::FUNC_START: begin
                            if (dur_we) begin
                                n_startp[req_idx] = 1'b1;
                            end
                        end
                        dost_pkg::FUNC_STOP: begin
                            if (id_ok) begin
                                n_stop[req_idx0] = r_stop[req_idx0] | r_active[req_idx0];
                                n_stop[req_idx1] = r_stop[req_idx1] | r_active[req_idx1];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APPLY: begin
                // Drop stopped slots, then bring in pending starts
                n_active = (r_active & ~r_stop) | r_startp;
                n_fresh  = r_startp;
                n_stop   = '0;
                n_startp = '0;
                n_kind   = dost_pkg::KIND_PLAIN;
                n_num    = '0;
                n_state  = ST_WALK;
            end
            ST_WALK: begin
                // Issue one slot read per cycle
                n_b_vld = 1'b1;
                if (r_num == NUM_W'(TIMER_SLOTS - 1)) begin
                    n_num = '0;
                    if (r_kind == dost_pkg::KIND_TICKED) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_kind = dost_pkg::KIND_TICKED;
                    end
                end else begin
                    n_num = r_num + NUM_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                // Send the held event as the last of this tick
                if (r_hold_vld) begin
                    n_strobe   = 1'b1;
                    n_out      = r_hold;
                    n_out.last = 1'b1;
                    n_hold_vld = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Stage B: count the slot, mark expiry stops, hold the new event
        if (b_live) begin
            if (b_res.expired) begin
                n_stop[b_idx0] = r_stop[b_idx0] | r_active[b_idx0];
                n_stop[b_idx1] = r_stop[b_idx1] | r_active[b_idx1];
            end
            if (b_res.emit) begin
                if (r_hold_vld) begin
                    n_strobe = 1'b1;
                    n_out    = r_hold;
                end
                n_hold     = b_evt;
                n_hold_vld = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= '0;
            r_startp   <= '0;
            r_stop     <= '0;
            r_fresh    <= '0;
            r_kind     <= dost_pkg::KIND_PLAIN;
            r_num      <= '0;
            r_b_vld    <= 1'b0;
            r_hold_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_startp   <= n_startp;
            r_stop     <= n_stop;
            r_fresh    <= n_fresh;
            r_kind     <= n_kind;
            r_num      <= n_num;
            r_b_vld    <= n_b_vld;
            r_hold_vld <= n_hold_vld;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_delta  <= n_delta;
        r_b_kind <= r_kind;
        r_b_num  <= r_num;
        r_hold   <= n_hold;
        r_out    <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_evt    = r_out;

endmodule

// ===== hdl/dost_slot_ram.sv =====
// ----------------------------------------------------------------------------
// dost_slot_ram
// Simple dual-port slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dost_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dost_unit.sv =====
// ----------------------------------------------------------------------------
// dost_unit
// Shared slot unit: saturating elapsed-time add, expiry compare, event decode.
// ----------------------------------------------------------------------------
module dost_unit #(
    parameter int TIME_WIDTH = dost_pkg::DEF_TIME_WIDTH
) (
    input  logic [TIME_WIDTH-1:0] i_base,
    input  logic [TIME_WIDTH-1:0] i_delta,
    input  logic [TIME_WIDTH-1:0] i_duration,
    input  logic                  i_kind,
    output logic [TIME_WIDTH-1:0] o_sum,
    output dost_pkg::t_unit_res   o_res
);

    logic [TIME_WIDTH:0] sum_ext;

    // Add with carry out, clamp on overflow
    assign sum_ext = {1'b0, i_base} + {1'b0, i_delta};
    assign o_sum   = sum_ext[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum_ext[TIME_WIDTH-1:0];

    // Plain slots report expiry, ticked slots report progress until expiry
    always_comb begin
        o_res.expired = (o_sum >= i_duration);
        o_res.emit    = (i_kind == dost_pkg::KIND_PLAIN) ? o_res.expired : !o_res.expired;
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deferred one-shot timer array. Directed
// requests cover zero, saturating and all-ones times, every function code
// and the corner cases of deferred start and stop. Random traffic follows
// in phases with different sender gaps. A local timer model predicts every
// event, and each strobed event is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSLOT = dost_pkg::DEF_TIMER_SLOTS;
    localparam int NALL = 2 * NSLOT;
    // Wait allowance for one tick, sized from the number of slots
    localparam int TICK_CYCLES = 2 * NSLOT + 8;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           start;
    dost_pkg::t_req i_req;
    logic           busy;
    logic           o_strobe;
    dost_pkg::t_evt o_evt;

    // Timer model state, indexed by kind * NSLOT + number
    bit          tmr_active[NALL];
    bit          tmr_start_due[NALL];
    bit          tmr_stop_due[NALL];
    logic [31:0] tmr_duration[NALL];
    logic [31:0] tmr_elapsed[NALL];
    logic [31:0] tmr_next_duration[NALL];

    dost_pkg::t_evt due_events[$];
    int   n_fail = 0;
    int   n_requests = 0;
    int   n_ticks = 0;
    int   n_events = 0;

    deferred_one_shot_timer_array u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_evt    (o_evt)
    );

    always #4 i_clk = ~i_clk;

    // Mark active slots of both tables for a stop at the next tick
    function automatic void mark_stop(input int num);
        for (int k = 0; k < 2; k++) begin
            if (tmr_active[k * NSLOT + num]) begin
                tmr_stop_due[k * NSLOT + num] = 1'b1;
            end
        end
    endfunction

    // Advance the timer model by one request and queue the events it raises
    function automatic void advance_timers(input dost_pkg::t_req r);
        dost_pkg::t_evt evs[NALL];
        int             n_ev;
        int             s;
        logic [32:0]    sum;
        bit             expired;
        bit             emit;
        n_ev = 0;
        s = int'(r.timer_kind) * NSLOT + int'(r.timer_id);
        case (r.func)
            dost_pkg::FUNC_TICK: begin
                for (int i = 0; i < NALL; i++) begin
                    if (tmr_stop_due[i]) begin
                        tmr_active[i] = 1'b0;
                        tmr_stop_due[i] = 1'b0;
                    end
                end
                for (int i = 0; i < NALL; i++) begin
                    if (tmr_start_due[i]) begin
                        tmr_active[i] = 1'b1;
                        tmr_duration[i] = tmr_next_duration[i];
                        tmr_elapsed[i] = '0;
                        tmr_start_due[i] = 1'b0;
                    end
                end
                for (int i = 0; i < NALL; i++) begin
                    if (!tmr_active[i]) continue;
                    sum = {1'b0, tmr_elapsed[i]} + {1'b0, r.delta};
                    tmr_elapsed[i] = sum[32] ? '1 : sum[31:0];
                    expired = tmr_elapsed[i] >= tmr_duration[i];
                    if (expired) mark_stop(i % NSLOT);
                    emit = (i < NSLOT) ? expired : !expired;
                    if (emit) begin
                        evs[n_ev].event_kind = (i < NSLOT) ? dost_pkg::KIND_PLAIN
                                                           : dost_pkg::KIND_TICKED;
                        evs[n_ev].event_id = 4'(i % NSLOT);
                        evs[n_ev].event_delta = (i < NSLOT) ? 32'd0 : r.delta;
                        evs[n_ev].last = 1'b0;
                        n_ev++;
                    end
                end
                if (n_ev > 0) evs[n_ev - 1].last = 1'b1;
                for (int i = 0; i < n_ev; i++) due_events.push_back(evs[i]);
            end
            dost_pkg::FUNC_START: begin
                if (!tmr_active[s] && !tmr_start_due[s]) begin
                    tmr_start_due[s] = 1'b1;
                    tmr_next_duration[s] = r.duration;
                end
            end
            dost_pkg::FUNC_STOP: begin
                mark_stop(int'(r.timer_id));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic dost_pkg::t_req make_req(input logic [1:0] func, input logic kind,
                                                input logic [3:0] id,
                                                input logic [31:0] dur,
                                                input logic [31:0] delta);
        dost_pkg::t_req r;
        r.func = func;
        r.timer_kind = kind;
        r.timer_id = id;
        r.duration = dur;
        r.delta = delta;
        return r;
    endfunction

    // Mostly short times so timers expire often, sometimes any 32-bit value, zero or all-ones
    function automatic logic [31:0] random_time(input logic [31:0] short_max);
        int pick;
        pick = int'($urandom_range(99));
        if (pick < 70) return $urandom_range(short_max, 0);
        if (pick < 85) return $urandom;
        if (pick < 92) return '0;
        return '1;
    endfunction

    function automatic dost_pkg::t_req random_req();
        dost_pkg::t_req r;
        int             pick;
        pick = int'($urandom_range(99));
        if (pick < 30) r.func = dost_pkg::FUNC_TICK;
        else if (pick < 75) r.func = dost_pkg::FUNC_START;
        else if (pick < 94) r.func = dost_pkg::FUNC_STOP;
        else r.func = FUNC_UNUSED;
        r.timer_kind = 1'($urandom_range(1));
        r.timer_id = 4'($urandom_range(NSLOT - 1));
        r.duration = random_time(32'h0006_0000);
        r.delta = random_time(32'h0002_0000);
        return r;
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_req(input dost_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        advance_timers(r);
        n_requests++;
        if (r.func == dost_pkg::FUNC_TICK) n_ticks++;
    endtask

    // Drop start for a random stretch, mostly short, sometimes a whole tick
    task automatic sender_gap(input int pct);
        int len;
        if ($urandom_range(99) < pct) begin
            len = ($urandom_range(3) == 0) ? int'($urandom_range(TICK_CYCLES + 4, 1))
                                           : int'($urandom_range(6, 1));
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted event has come, then let the block settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (due_events.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (due_events.size() != 0) begin
            $error("%0d predicted events never arrived", due_events.size());
            n_fail++;
        end
        repeat (TICK_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int gap_pct);
        for (int i = 0; i < count; i++) begin
            sender_gap(gap_pct);
            send_req(random_req());
        end
    endtask

    task automatic test_directed_cases();
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0, 32'd0));
        // zero duration expires on the first tick; the first pending start wins
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_PLAIN, 4'd0, 32'd0, 32'd0));
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_PLAIN, 4'd0, 32'h5, 32'd0));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0, 32'd0));
        // expired slot stays active until the next tick, so this is dropped
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_PLAIN, 4'd0, 32'h10, 32'd0));
        // stop of a slot that is only waiting to start does nothing
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_TICKED, 4'd15,
                          32'h0003_0000, 32'd0));
        send_req(make_req(dost_pkg::FUNC_STOP, dost_pkg::KIND_PLAIN, 4'd15, 32'd0, 32'd0));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0,
                          32'h0001_0000));
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_TICKED, 4'd15, 32'h1, 32'd0));
        // plain expiry and ticked progress on the same number in one tick
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_PLAIN, 4'd15,
                          32'h0001_0000, 32'd0));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0,
                          32'h0001_0000));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_TICKED, 4'd15, '1,
                          32'h0001_0000));
        // saturation at all-ones, zero-duration ticked slot raises no progress
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_TICKED, 4'd7, '1, 32'd0));
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_TICKED, 4'd8, 32'd0, 32'd0));
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_PLAIN, 4'd3,
                          32'h0002_0000, 32'd0));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0,
                          32'h8000_0001));
        send_req(make_req(dost_pkg::FUNC_STOP, dost_pkg::KIND_TICKED, 4'd3, '1, '1));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0,
                          32'h8000_0001));
        // stop reaches both tables; the unused code changes nothing
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_PLAIN, 4'd9, '1, 32'd0));
        send_req(make_req(dost_pkg::FUNC_START, dost_pkg::KIND_TICKED, 4'd9, '1, 32'd0));
        send_req(make_req(FUNC_UNUSED, dost_pkg::KIND_TICKED, 4'd15, '1, '1));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0, 32'h1));
        send_req(make_req(dost_pkg::FUNC_STOP, dost_pkg::KIND_PLAIN, 4'd9, 32'd0, 32'd0));
        send_req(make_req(dost_pkg::FUNC_TICK, dost_pkg::KIND_PLAIN, 4'd0, 32'd0, '1));
        wait_drained();
    endtask

    task automatic test_back_to_back();
        run_random(170, 0);
        wait_drained();
    endtask

    task automatic test_sparse_sender();
        run_random(170, 68);
        wait_drained();
    endtask

    task automatic test_light_gaps();
        run_random(170, 19);
        wait_drained();
    endtask

    // Compare each strobed event with the oldest prediction
    always @(posedge i_clk) begin
        dost_pkg::t_evt want;
        if (i_rst_n && o_strobe) begin
            n_events++;
            if (due_events.size() == 0) begin
                $error("unexpected event kind=%0d id=%0d", o_evt.event_kind, o_evt.event_id);
                n_fail++;
            end else begin
                want = due_events.pop_front();
                if (o_evt.event_kind !== want.event_kind) begin
                    $error("event_kind: expected %0d, got %0d", want.event_kind,
                           o_evt.event_kind);
                    n_fail++;
                end
                if (o_evt.event_id !== want.event_id) begin
                    $error("event_id: expected %0d, got %0d", want.event_id, o_evt.event_id);
                    n_fail++;
                end
                if (o_evt.event_delta !== want.event_delta) begin
                    $error("event_delta: expected %h, got %h", want.event_delta,
                           o_evt.event_delta);
                    n_fail++;
                end
                if (o_evt.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_evt.last);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed_cases();
        test_back_to_back();
        test_sparse_sender();
        test_light_gaps();
        $display("Covered %0d requests including %0d ticks; %0d events checked",
                 n_requests, n_ticks, n_events);
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
